FILE: design/ctp_pkg.sv
`timescale 1ns / 1ps

package ctp_pkg;

    localparam int MAX_THREADS_DEF = 16;

    localparam int ADDR_W = 16;
    localparam int ID_W   = 8;
    localparam int PRI_W  = 8;
    localparam int TIME_W = 64;

    // priority seen as "previous" before the first switch
    localparam logic [PRI_W-1:0] PRI_RESET = 8'd255;

    typedef struct packed {
        logic load;
        logic rd_issue;
        logic update;
    } t_dp_cmd;

    typedef struct packed {
        logic count_zero;
        logic last_issue;
        logic out_free;
    } t_dp_status;

endpackage

FILE: design/ctp_ctrl.sv
`timescale 1ns / 1ps

module ctp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  ctp_pkg::t_dp_status i_status,
    output ctp_pkg::t_dp_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_UPDATE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd.load     = 1'b0;
        o_cmd.rd_issue = 1'b0;
        o_cmd.update   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.count_zero ? S_UPDATE : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd_issue = 1'b1;
                if (i_status.last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            // last read word is compared here
            S_DRAIN: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (i_status.out_free) begin
                    o_cmd.update = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

FILE: design/ctp_datapath.sv
`timescale 1ns / 1ps

module ctp_datapath #(
    parameter int MAX_THREADS = ctp_pkg::MAX_THREADS_DEF,
    parameter int CW          = $clog2(MAX_THREADS + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ctp_pkg::t_dp_cmd            i_cmd,
    output ctp_pkg::t_dp_status         o_status,
    input  logic [ctp_pkg::ADDR_W-1:0]  i_thread_addr,
    input  logic [ctp_pkg::ID_W-1:0]    i_thread_id,
    input  logic [ctp_pkg::PRI_W-1:0]   i_base_priority,
    input  logic [ctp_pkg::PRI_W-1:0]   i_inherited_priority,
    input  logic [ctp_pkg::TIME_W-1:0]  i_timestamp,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [ctp_pkg::ID_W-1:0]    o_trace_id,
    output logic [ctp_pkg::PRI_W-1:0]   o_trace_priority,
    output logic [ctp_pkg::TIME_W-1:0]  o_trace_time,
    output logic [ctp_pkg::TIME_W-1:0]  o_credited_cycles,
    output logic [ctp_pkg::TIME_W-1:0]  o_idle_cycles,
    output logic [CW-1:0]               o_known_count,
    output logic                        o_added_entry,
    output logic                        o_table_full
);

    localparam int IW = $clog2(MAX_THREADS);
    localparam int AW = ctp_pkg::ADDR_W;
    localparam int DW = ctp_pkg::ID_W;
    localparam int PW = ctp_pkg::PRI_W;
    localparam int TW = ctp_pkg::TIME_W;

    // thread table
    logic [AW-1:0]          mem_addr   [MAX_THREADS];
    logic [DW-1:0]          mem_id     [MAX_THREADS];
    logic [TW-1:0]          mem_cycles [MAX_THREADS];
    logic [MAX_THREADS-1:0] r_active;

    // incoming switch
    logic [AW-1:0] r_addr;
    logic [DW-1:0] r_id;
    logic [PW-1:0] r_pri;
    logic [TW-1:0] r_time;
    logic [TW-1:0] r_elapsed;
    logic          r_credit_en;

    // state left by the last switch
    logic [AW-1:0] r_prev_addr;
    logic [DW-1:0] r_prev_id;
    logic [PW-1:0] r_prev_pri;
    logic [TW-1:0] r_prev_time;
    logic          r_prev_valid;
    logic [TW-1:0] r_idle;
    logic [CW-1:0] r_count;

    // scan
    logic [IW-1:0] r_idx;
    logic          r_rd_vld;
    logic [IW-1:0] r_rd_idx;
    logic [AW-1:0] r_rd_addr;
    logic [DW-1:0] r_rd_id;
    logic [TW-1:0] r_rd_cycles;
    logic          r_known;
    logic          r_credit_hit;

    logic          r_out_valid;

    logic          w_addr_hit;
    logic          w_cur_known;
    logic          w_cur_stale;
    logic          w_prev_hit;
    logic          w_room;
    logic          w_new_pair;
    logic          w_append;
    logic [IW-1:0] w_app_idx;
    logic          w_cyc_we;
    logic [IW-1:0] w_cyc_idx;
    logic [TW-1:0] w_cyc_data;
    logic          w_act_we;
    logic [IW-1:0] w_act_idx;
    logic          w_act_data;
    logic [TW-1:0] n_idle;
    logic [CW-1:0] n_count;

    assign w_addr_hit  = r_rd_vld && (r_addr != '0) && (r_rd_addr == r_addr);
    assign w_cur_known = w_addr_hit && (r_rd_id == r_id);
    assign w_cur_stale = w_addr_hit && (r_rd_id != r_id);
    assign w_prev_hit  = r_rd_vld && r_credit_en && (r_rd_addr == r_prev_addr)
                         && (r_rd_id == r_prev_id);

    assign w_room     = (r_count < CW'(MAX_THREADS));
    assign w_new_pair = (r_addr != '0) && !r_known;
    assign w_append   = i_cmd.update && w_new_pair && w_room;
    assign w_app_idx  = r_count[IW-1:0];

    assign n_idle  = (r_prev_pri == '0) ? r_idle + r_elapsed : r_idle;
    assign n_count = w_append ? r_count + CW'(1) : r_count;

    // one write port per store: scan write-back, or append during update
    always_comb begin
        w_cyc_we   = 1'b0;
        w_cyc_idx  = r_rd_idx;
        w_cyc_data = r_rd_cycles + r_elapsed;
        w_act_we   = 1'b0;
        w_act_idx  = r_rd_idx;
        w_act_data = 1'b0;
        priority if (w_append) begin
            w_cyc_we   = 1'b1;
            w_cyc_idx  = w_app_idx;
            w_cyc_data = '0;
            w_act_we   = 1'b1;
            w_act_idx  = w_app_idx;
            w_act_data = 1'b1;
        end else begin
            w_cyc_we = w_prev_hit;
            w_act_we = w_cur_stale;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_append) begin
            mem_addr[w_app_idx] <= r_addr;
            mem_id[w_app_idx]   <= r_id;
        end
        if (w_cyc_we) begin
            mem_cycles[w_cyc_idx] <= w_cyc_data;
        end
        if (w_act_we) begin
            r_active[w_act_idx] <= w_act_data;
        end
        if (i_cmd.rd_issue) begin
            r_rd_addr   <= mem_addr[r_idx];
            r_rd_id     <= mem_id[r_idx];
            r_rd_cycles <= mem_cycles[r_idx];
            r_rd_idx    <= r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr      <= i_thread_addr;
            r_id        <= i_thread_id;
            r_pri       <= (i_inherited_priority != '0) ? i_inherited_priority
                                                         : i_base_priority;
            r_time      <= i_timestamp;
            r_elapsed   <= i_timestamp - r_prev_time;
            r_credit_en <= r_prev_valid && (r_prev_time != '0);
        end
        if (i_cmd.load) begin
            r_idx <= '0;
        end else if (i_cmd.rd_issue) begin
            r_idx <= r_idx + IW'(1);
        end
        if (i_cmd.load) begin
            r_known      <= 1'b0;
            r_credit_hit <= 1'b0;
        end else begin
            r_known      <= r_known | w_cur_known;
            r_credit_hit <= r_credit_hit | w_prev_hit;
        end
        if (i_cmd.update) begin
            o_trace_id        <= r_id;
            o_trace_priority  <= r_pri;
            o_trace_time      <= r_time;
            o_credited_cycles <= r_credit_hit ? r_elapsed : '0;
            o_idle_cycles     <= n_idle;
            o_known_count     <= n_count;
            o_added_entry     <= w_append;
            o_table_full      <= w_new_pair && !w_room;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_addr  <= '0;
            r_prev_id    <= '0;
            r_prev_pri   <= ctp_pkg::PRI_RESET;
            r_prev_time  <= '0;
            r_prev_valid <= 1'b0;
            r_idle       <= '0;
            r_count      <= '0;
            r_rd_vld     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_issue;
            if (i_cmd.update) begin
                r_prev_addr  <= r_addr;
                r_prev_id    <= r_id;
                r_prev_pri   <= r_pri;
                r_prev_time  <= r_time;
                r_prev_valid <= 1'b1;
                r_idle       <= n_idle;
                r_count      <= n_count;
                r_out_valid  <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid             = r_out_valid;
    assign o_status.count_zero = (r_count == '0);
    assign o_status.last_issue = (CW'(r_idx) == r_count - CW'(1));
    assign o_status.out_free   = !r_out_valid || i_ready;

endmodule

FILE: design/thread_cycle_profiler.sv
`timescale 1ns / 1ps

// steps: idle takes the input word, scan reads the N table entries in use (skipped with an empty
// table), drain compares the last read word, update registers the result word
// a new switch is taken only after the update, which waits while a held result word blocks it;
// one table entry read per cycle
// reset: synchronous active low; clears counts, idle total and previous-thread state,
// table contents stay undefined until written

module thread_cycle_profiler #(
    parameter int MAX_THREADS = ctp_pkg::MAX_THREADS_DEF,
    parameter int CW          = $clog2(MAX_THREADS + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [ctp_pkg::ADDR_W-1:0]  i_thread_addr,
    input  logic [ctp_pkg::ID_W-1:0]    i_thread_id,
    input  logic [ctp_pkg::PRI_W-1:0]   i_base_priority,
    input  logic [ctp_pkg::PRI_W-1:0]   i_inherited_priority,
    input  logic [ctp_pkg::TIME_W-1:0]  i_timestamp,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [ctp_pkg::ID_W-1:0]    o_trace_id,
    output logic [ctp_pkg::PRI_W-1:0]   o_trace_priority,
    output logic [ctp_pkg::TIME_W-1:0]  o_trace_time,
    output logic [ctp_pkg::TIME_W-1:0]  o_credited_cycles,
    output logic [ctp_pkg::TIME_W-1:0]  o_idle_cycles,
    output logic [CW-1:0]               o_known_count,
    output logic                        o_added_entry,
    output logic                        o_table_full
);

    ctp_pkg::t_dp_cmd    w_cmd;
    ctp_pkg::t_dp_status w_status;

    ctp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    ctp_datapath #(
        .MAX_THREADS (MAX_THREADS),
        .CW          (CW)
    ) u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .o_status             (w_status),
        .i_thread_addr        (i_thread_addr),
        .i_thread_id          (i_thread_id),
        .i_base_priority      (i_base_priority),
        .i_inherited_priority (i_inherited_priority),
        .i_timestamp          (i_timestamp),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_trace_id           (o_trace_id),
        .o_trace_priority     (o_trace_priority),
        .o_trace_time         (o_trace_time),
        .o_credited_cycles    (o_credited_cycles),
        .o_idle_cycles        (o_idle_cycles),
        .o_known_count        (o_known_count),
        .o_added_entry        (o_added_entry),
        .o_table_full         (o_table_full)
    );

endmodule

FILE: design/ctp_checker.sv
`timescale 1ns / 1ps

module ctp_checker #(
    parameter int CW = $clog2(ctp_pkg::MAX_THREADS_DEF + 1)
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [ctp_pkg::TIME_W-1:0]  o_trace_time,
    input logic [ctp_pkg::TIME_W-1:0]  o_idle_cycles,
    input logic [CW-1:0]               o_known_count,
    input logic                        o_added_entry,
    input logic                        o_table_full
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_trace_time)
            && $stable(o_idle_cycles) && $stable(o_known_count))
        else $error("result word changed while stalled");

    a_add_or_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_added_entry && o_table_full))
        else $error("entry both added and dropped");

    a_add_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_added_entry |-> o_known_count != '0)
        else $error("entry added with empty table count");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind thread_cycle_profiler ctp_checker #(.CW(CW)) u_ctp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_trace_time  (o_trace_time),
    .o_idle_cycles (o_idle_cycles),
    .o_known_count (o_known_count),
    .o_added_entry (o_added_entry),
    .o_table_full  (o_table_full)
);
